// ===== rtl/lfu_kvc_pkg.sv =====
// Package for the LFU key-value cache: request and response payloads,
// controller command/status structs and fixed constants.
// No dependencies.
package lfu_kvc_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 31;
  localparam int unsigned CFG_W = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;
    logic step;
    logic apply;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cap_zero;
    logic scan_last;
  } sts_t;

endpackage

// ===== rtl/lfu_kvc_ctrl.sv =====
// Controller of the LFU key-value cache: sequences load, scan, update and
// response of one request. Depends on lfu_kvc_pkg.
module lfu_kvc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output lfu_kvc_pkg::cmd_t   cmd,
  input  lfu_kvc_pkg::sts_t   sts
);
  import lfu_kvc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = sts.cap_zero ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESP);

endmodule

// ===== rtl/lfu_kvc_dp.sv =====
// Datapath of the LFU key-value cache: entry storage, sequential scan for
// key match, victim and free slot, and the update step. Depends on lfu_kvc_pkg.
module lfu_kvc_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [lfu_kvc_pkg::CFG_W-1:0]        cfg_wr_data,
  input  lfu_kvc_pkg::req_t                    req,
  input  lfu_kvc_pkg::cmd_t                    cmd,
  output lfu_kvc_pkg::sts_t                    sts,
  output lfu_kvc_pkg::rsp_t                    rsp
);
  import lfu_kvc_pkg::*;

  // max_entries is five bits wide, so no more than 31 slots are ever used
  localparam int unsigned DEPTH = (CAPACITY < 31) ? CAPACITY : 31;
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CFG_W-1:0] DEPTH_C = CFG_W'(DEPTH);

  logic [DEPTH-1:0]          valid_r;
  logic [KEY_W-1:0]          key_r   [DEPTH];
  logic [VAL_W-1:0]          data_r  [DEPTH];
  logic [CNT_W-1:0]          count_r [DEPTH];
  logic [IW-1:0]             rank_r  [DEPTH];
  logic [CFG_W-1:0]          occ_r;
  logic [CFG_W-1:0]          max_r;

  req_t                      req_r;
  rsp_t                      rsp_r;
  logic [CFG_W-1:0]          cnt_r;
  logic                      found_r, have_r, free_ok_r;
  logic [IW-1:0]             slot_r, vic_r, free_r;
  logic [VAL_W-1:0]          fdata_r;
  logic [CNT_W-1:0]          vcnt_r;
  logic [IW-1:0]             vrank_r;

  logic [CFG_W-1:0]          cap;
  logic [IW-1:0]             idx;
  logic                      evict;
  logic [IW-1:0]             tgt;
  logic [IW-1:0]             old_rank;

  assign cap      = (max_r < DEPTH_C) ? max_r : DEPTH_C;
  assign idx      = cnt_r[IW-1:0];
  assign evict    = (occ_r >= cap);
  assign tgt      = evict ? vic_r : free_r;
  assign old_rank = rank_r[slot_r];

  assign sts.cap_zero  = (cap == '0);
  assign sts.scan_last = (cnt_r == cap - 1'b1);
  assign rsp           = rsp_r;

  // Capture request, run scan and produce the response
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r          <= req;
      cnt_r          <= '0;
      found_r        <= 1'b0;
      have_r         <= 1'b0;
      free_ok_r      <= 1'b0;
      rsp_r.hit        <= 1'b0;
      rsp_r.read_value <= MISS_VALUE;
      rsp_r.evicted    <= 1'b0;
    end
    if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
      if (valid_r[idx]) begin
        if (!found_r && key_r[idx] == req_r.lookup_key) begin
          found_r <= 1'b1;
          slot_r  <= idx;
          fdata_r <= data_r[idx];
        end
        if (!have_r || count_r[idx] < vcnt_r ||
            (count_r[idx] == vcnt_r && rank_r[idx] > vrank_r)) begin
          have_r  <= 1'b1;
          vic_r   <= idx;
          vcnt_r  <= count_r[idx];
          vrank_r <= rank_r[idx];
        end
      end else if (!free_ok_r) begin
        free_ok_r <= 1'b1;
        free_r    <= idx;
      end
    end
    if (cmd.apply) begin
      if (found_r) begin
        rsp_r.hit        <= 1'b1;
        rsp_r.read_value <= (req_r.opcode == OP_PUT) ? req_r.write_value : fdata_r;
      end else if (req_r.opcode == OP_PUT) begin
        rsp_r.read_value <= req_r.write_value;
        rsp_r.evicted    <= evict;
      end
    end
  end

  // Entry store: configuration clear and update step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      max_r   <= MAX_ENTRIES_RST;
    end else if (cfg_wr_en) begin
      valid_r <= '0;
      occ_r   <= '0;
      max_r   <= cfg_wr_data;
    end else if (cmd.apply) begin
      if (found_r) begin
        // touch: younger entries age by one
        for (int i = 0; i < DEPTH; i++) begin
          if (valid_r[i] && IW'(i) != slot_r && rank_r[i] < old_rank)
            rank_r[i] <= rank_r[i] + 1'b1;
        end
        rank_r[slot_r] <= '0;
        if (count_r[slot_r] != COUNT_MAX) count_r[slot_r] <= count_r[slot_r] + 1'b1;
        if (req_r.opcode == OP_PUT) data_r[slot_r] <= req_r.write_value;
      end else if (req_r.opcode == OP_PUT) begin
        // plain insert ages all other entries; evict-and-insert ages only entries younger than the victim
        for (int i = 0; i < DEPTH; i++) begin
          if (valid_r[i] && IW'(i) != tgt && (!evict || rank_r[i] < vrank_r))
            rank_r[i] <= rank_r[i] + 1'b1;
        end
        valid_r[tgt] <= 1'b1;
        key_r[tgt]   <= req_r.lookup_key;
        data_r[tgt]  <= req_r.write_value;
        count_r[tgt] <= CNT_W'(1);
        rank_r[tgt]  <= '0;
        if (!evict) occ_r <= occ_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lfu_kvc_top.sv =====
// LFU key-value cache top level: one request at a time, sequential scan.
// The scan covers min(max_entries, CAPACITY, 31) entries, one entry per cycle over the store;
// at capacity 0 the scan is skipped. A new request is taken only once the controller is
// back in idle after the response has been taken.
// Synchronous active-low reset empties the store and sets max_entries to 16.
// Writing cfg_wr_data empties the store at once.
module lfu_key_value_cache_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lfu_kvc_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lfu_kvc_pkg::req_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lfu_kvc_pkg::rsp_t                 out_data
);
  import lfu_kvc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  lfu_kvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Storage and scan
  lfu_kvc_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .rsp         (out_data)
  );

  // One request in flight: no acceptance while a response is shown
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while response pending");

  // An eviction only ever comes with a miss
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> !out_data.hit)
    else $error("eviction reported on a hit");

  // Accepting a request always leaves the ready state next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("controller did not leave idle after accept");

endmodule

// ===== dv/lfu_key_value_cache_top_tb.sv =====
// Testbench for the LFU key-value cache: a behavioural cache model predicts
// each response, which is checked in order against the block's output.
// Depends on lfu_kvc_pkg and lfu_key_value_cache_top.
module lfu_key_value_cache_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfu_kvc_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam logic [31:0] COUNT_TOP = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  lfu_key_value_cache_top #(.CAPACITY(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Cache model state
  logic [4:0]  cache_limit;
  logic        slot_used [SLOTS];
  logic [31:0] slot_key [SLOTS];
  logic [31:0] slot_data [SLOTS];
  logic [31:0] slot_uses [SLOTS];
  logic [31:0] slot_age [SLOTS];
  int unsigned fill_level;

  rsp_t pending_rsp [$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 0;
  // Small key pool so that hits and evictions are frequent
  logic [31:0] key_pool [8];

  function automatic void empty_cache();
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    fill_level = 0;
  endfunction

  // Make slot s the youngest; younger entries age one step
  function automatic void refresh_age(int s);
    logic [31:0] old_age;
    old_age = slot_age[s];
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && i != s && slot_age[i] < old_age) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic rsp_t cache_access(req_t rq);
    rsp_t rs;
    int unsigned lim;
    int s;
    int victim;
    logic [31:0] va;
    rs.hit = 1'b0;
    rs.read_value = MISS_VALUE;
    rs.evicted = 1'b0;
    lim = (cache_limit < SLOTS) ? cache_limit : SLOTS;
    if (lim == 0) return rs;
    s = -1;
    for (int i = 0; i < lim; i++)
      if (s < 0 && slot_used[i] && slot_key[i] == rq.lookup_key) s = i;
    if (s >= 0) begin
      if (rq.opcode == OP_PUT) slot_data[s] = rq.write_value;
      if (slot_uses[s] < COUNT_TOP) slot_uses[s]++;
      refresh_age(s);
      rs.hit = 1'b1;
      rs.read_value = slot_data[s];
      return rs;
    end
    if (rq.opcode == OP_GET) return rs;
    // Evict the least used entry, the oldest among ties
    if (fill_level >= lim) begin
      victim = -1;
      for (int i = 0; i < lim; i++) begin
        if (!slot_used[i]) continue;
        if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
            (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim]))
          victim = i;
      end
      if (victim >= 0) begin
        va = slot_age[victim];
        slot_used[victim] = 1'b0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_used[i] && slot_age[i] > va) slot_age[i]--;
        if (fill_level > 0) fill_level--;
        rs.evicted = 1'b1;
      end
    end
    s = -1;
    for (int i = 0; i < lim; i++)
      if (s < 0 && !slot_used[i]) s = i;
    if (s < 0) return rs;
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i]) slot_age[i]++;
    slot_used[s] = 1'b1;
    slot_key[s] = rq.lookup_key;
    slot_data[s] = rq.write_value;
    slot_uses[s] = 1;
    slot_age[s] = 0;
    fill_level++;
    rs.read_value = rq.write_value;
    return rs;
  endfunction

  // Offer one request, hold it until accepted, then predict its response;
  // valid stays high after acceptance until the next idle cycle or drain
  task automatic send_request(logic op, logic [31:0] k, logic [31:0] v);
    req_t rq;
    rq.opcode = op;
    rq.lookup_key = k;
    rq.write_value = v;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rsp.insert(pending_rsp.size(), cache_access(rq));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] lim);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cache_limit = lim;
    empty_cache();
  endtask

  // Drive the stall line of the response channel
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Check each response against the oldest prediction
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", out_data);
      end else begin
        want = pending_rsp[0];
        pending_rsp.delete(0);
        if (out_data.hit !== want.hit || out_data.read_value !== want.read_value ||
            out_data.evicted !== want.evicted) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: expected %p actual %p", want, out_data);
        end
      end
    end
  end

  task automatic test_directed();
    // Extremes, misses, updates, new puts
    send_request(OP_GET, 32'h8000_0000, 32'h0);
    send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_PUT, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'h8000_0000, 32'h1234);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h0);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
    // Capacity 1: each new put after the first evicts the sole entry
    write_limit(5'd1);
    send_request(OP_PUT, 32'd5, 32'd50);
    send_request(OP_PUT, 32'd6, 32'd60);
    send_request(OP_GET, 32'd5, 32'd0);
    send_request(OP_GET, 32'd6, 32'd0);
    // Capacity 2: frequency then recency tie break
    write_limit(5'd2);
    send_request(OP_PUT, 32'd1, 32'd10);
    send_request(OP_PUT, 32'd2, 32'd20);
    send_request(OP_PUT, 32'd3, 32'd30);
    send_request(OP_GET, 32'd3, 32'd0);
    send_request(OP_PUT, 32'd4, 32'd40);
    send_request(OP_GET, 32'd2, 32'd0);
    // Capacity zero ignores everything
    write_limit(5'd0);
    send_request(OP_PUT, 32'd1, 32'd1);
    send_request(OP_GET, 32'd1, 32'd0);
    // Above the parameter: saturates to full size
    write_limit(5'd31);
    send_request(OP_PUT, 32'd9, 32'd90);
    send_request(OP_GET, 32'd9, 32'd0);
  endtask

  task automatic random_phase(int n);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
      send_request(1'($urandom_range(1)), k, $urandom());
    end
  endtask

  task automatic test_random();
    int unsigned idle_set [4] = '{0, 48, 0, 26};
    int unsigned stall_set [4] = '{0, 0, 48, 26};
    logic [4:0] limits [5] = '{5'd3, 5'd16, 5'd7, 5'd0, 5'd20};
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    for (int c = 0; c < 5; c++) begin
      write_limit(limits[c]);
      for (int p = 0; p < 4; p++) begin
        send_idle_pct = idle_set[p];
        recv_stall_pct = stall_set[p];
        random_phase(c == 3 ? 10 : 58);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Receiver holds off while requests keep coming
  task automatic test_backpressure();
    write_limit(5'd4);
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(8);
    join
  endtask

  initial begin
    cache_limit = MAX_ENTRIES_RST;
    empty_cache();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("lfu_key_value_cache_top test passed");
    end else begin
      $display("lfu_key_value_cache_top test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("lfu_key_value_cache_top test failed");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/lfu_kvc_pkg.sv
rtl/lfu_kvc_ctrl.sv
rtl/lfu_kvc_dp.sv
rtl/lfu_kvc_top.sv
dv/lfu_key_value_cache_top_tb.sv
